// ----- hdl/cdds_pkg.sv -----
package cdds_pkg;

    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int OFF_W    = 17;
    localparam int DN_OUT_W = 16;
    localparam int WD_W     = 3;
    localparam int YLEN_W   = 9;

    localparam logic [YLEN_W-1:0]  DAYS_COMMON = 9'd365;
    localparam logic [YLEN_W-1:0]  DAYS_LEAP   = 9'd366;
    localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
    localparam logic [MONTH_W-1:0] NUM_MONTHS  = 4'd12;
    localparam logic [6:0]         CENT_LAST   = 7'd99;
    localparam logic [8:0]         QCENT_LAST  = 9'd399;
    localparam int                 WEEK_DAYS   = 7;

    // datapath commands
    typedef struct packed {
        logic load;
        logic year_step;
        logic mon_step;
        logic finish;
        logic tgt_year_step;
        logic tgt_mon_step;
        logic wr_ok;
        logic wr_fail;
        logic wr_inv;
    } cmd_t;

    // datapath status
    typedef struct packed {
        logic in_ok;
        logic at_year;
        logic day_ok;
        logic mon_done;
        logic tgt_pos;
        logic tgt_gt_ylen;
        logic at_last;
        logic tgt_gt_mon;
        logic out_free;
    } sts_t;

    // month length, zero for codes outside 1..12
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // a + b mod 7, a below 7 and b at most 3
    function automatic logic [WD_W-1:0] add_mod7(input logic [WD_W-1:0] a,
                                                 input logic [1:0] b);
        logic [WD_W:0] s;
        s = {1'b0, a} + {2'b00, b};
        if (s >= 4'(WEEK_DAYS)) begin
            s = s - 4'(WEEK_DAYS);
        end
        return s[WD_W-1:0];
    endfunction

    // 6-bit value below 42, mod 7 by repeated subtraction
    function automatic logic [WD_W-1:0] fold_mod7(input logic [5:0] v);
        logic [5:0] r;
        r = v;
        for (int i = 0; i < 5; i++) begin
            if (r >= 6'(WEEK_DAYS)) begin
                r = r - 6'(WEEK_DAYS);
            end
        end
        return r[WD_W-1:0];
    endfunction

endpackage

// ----- hdl/cdds_ctrl.sv -----
module cdds_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  cdds_pkg::sts_t sts,
    output cdds_pkg::cmd_t cmd
);

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b00_0000_0001,
        ST_CHECK   = 10'b00_0000_0010,
        ST_YEAR1   = 10'b00_0000_0100,
        ST_MON1    = 10'b00_0000_1000,
        ST_FIN     = 10'b00_0001_0000,
        ST_YEAR2   = 10'b00_0010_0000,
        ST_MON2    = 10'b00_0100_0000,
        ST_WR_OK   = 10'b00_1000_0000,
        ST_WR_FAIL = 10'b01_0000_0000,
        ST_WR_INV  = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = sts.in_ok ? ST_YEAR1 : ST_WR_INV;
            end
            ST_YEAR1: begin
                if (sts.at_year) begin
                    state_next = sts.day_ok ? ST_MON1 : ST_WR_INV;
                end else begin
                    cmd.year_step = 1'b1;
                end
            end
            ST_MON1: begin
                if (sts.mon_done) begin
                    state_next = ST_FIN;
                end else begin
                    cmd.mon_step = 1'b1;
                end
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
                state_next = ST_YEAR2;
            end
            ST_YEAR2: begin
                if (!sts.tgt_pos) begin
                    state_next = ST_WR_FAIL;
                end else if (sts.tgt_gt_ylen) begin
                    if (sts.at_last) begin
                        state_next = ST_WR_FAIL;
                    end else begin
                        cmd.tgt_year_step = 1'b1;
                    end
                end else begin
                    state_next = ST_MON2;
                end
            end
            ST_MON2: begin
                if (sts.tgt_gt_mon) begin
                    cmd.tgt_mon_step = 1'b1;
                end else begin
                    state_next = ST_WR_OK;
                end
            end
            ST_WR_OK: begin
                if (sts.out_free) begin
                    cmd.wr_ok  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_WR_FAIL: begin
                if (sts.out_free) begin
                    cmd.wr_fail = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_WR_INV: begin
                if (sts.out_free) begin
                    cmd.wr_inv = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_accept_to_check: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && s_tvalid) |=> (state_reg == ST_CHECK))
        else $error("accepted word did not start a range check");

    a_fin_to_year2: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN) |=> (state_reg == ST_YEAR2))
        else $error("shift pass did not follow day number");
`endif

endmodule

// ----- hdl/cdds_dp.sv -----
module cdds_dp #(
    parameter int FIRST_YEAR = 1970,
    parameter int LAST_YEAR  = 2099
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic [cdds_pkg::YEAR_W-1:0]            in_year,
    input  logic [cdds_pkg::MONTH_W-1:0]           in_month,
    input  logic [cdds_pkg::DAY_W-1:0]             in_day,
    input  logic signed [cdds_pkg::OFF_W-1:0]      in_offset_days,
    input  cdds_pkg::cmd_t                         cmd,
    output cdds_pkg::sts_t                         sts,
    input  logic                                   m_tready,
    output logic                                   m_tvalid,
    output logic                                   out_date_valid,
    output logic [cdds_pkg::DN_OUT_W-1:0]          out_day_number,
    output logic [cdds_pkg::WD_W-1:0]              out_weekday,
    output logic                                   out_shift_ok,
    output logic [cdds_pkg::YEAR_W-1:0]            out_new_year,
    output logic [cdds_pkg::MONTH_W-1:0]           out_new_month,
    output logic [cdds_pkg::DAY_W-1:0]             out_new_day
);

    localparam int SPAN     = (LAST_YEAR >= FIRST_YEAR) ? LAST_YEAR - FIRST_YEAR + 1 : 1;
    localparam int DN_RAW_W = $clog2(SPAN * 366 + 1);
    localparam int DN_W     = (DN_RAW_W > cdds_pkg::DN_OUT_W) ? DN_RAW_W : cdds_pkg::DN_OUT_W;
    localparam int TGT_W    = ((DN_W > cdds_pkg::OFF_W) ? DN_W : cdds_pkg::OFF_W) + 2;
    localparam int P        = FIRST_YEAR - 1;
    localparam int BASE     = 365 * P + P / 4 - P / 100 + P / 400;

    localparam logic [cdds_pkg::WD_W-1:0]   WD0    = 3'(BASE % 7);
    localparam logic [6:0]                  F100   = 7'(FIRST_YEAR % 100);
    localparam logic [8:0]                  F400   = 9'(FIRST_YEAR % 400);
    localparam logic [cdds_pkg::YEAR_W-1:0] FIRST_Y = 12'(FIRST_YEAR);
    localparam logic [cdds_pkg::YEAR_W-1:0] LAST_Y  = 12'(LAST_YEAR);

    // captured input word
    logic [cdds_pkg::YEAR_W-1:0]       y_in_reg, y_in_next;
    logic [cdds_pkg::MONTH_W-1:0]      m_in_reg, m_in_next;
    logic [cdds_pkg::DAY_W-1:0]        d_in_reg, d_in_next;
    logic signed [cdds_pkg::OFF_W-1:0] off_reg,  off_next;

    // year walker with century counters for the leap rule
    logic [cdds_pkg::YEAR_W-1:0] year_reg, year_next;
    logic [6:0]                  c100_reg, c100_next;
    logic [8:0]                  c400_reg, c400_next;

    logic [DN_W-1:0]               dn_reg,  dn_next;
    logic [cdds_pkg::WD_W-1:0]     wd_reg,  wd_next;
    logic [cdds_pkg::MONTH_W-1:0]  mi_reg,  mi_next;
    logic signed [TGT_W-1:0]       tgt_reg, tgt_next;

    // output register
    logic                            ov_reg,  ov_next;
    logic                            o_dv_reg, o_dv_next;
    logic [cdds_pkg::DN_OUT_W-1:0]   o_dn_reg, o_dn_next;
    logic [cdds_pkg::WD_W-1:0]       o_wd_reg, o_wd_next;
    logic                            o_ok_reg, o_ok_next;
    logic [cdds_pkg::YEAR_W-1:0]     o_y_reg,  o_y_next;
    logic [cdds_pkg::MONTH_W-1:0]    o_m_reg,  o_m_next;
    logic [cdds_pkg::DAY_W-1:0]      o_d_reg,  o_d_next;

    logic                          leap;
    logic [cdds_pkg::YLEN_W-1:0]   ylen;
    logic [1:0]                    ylen_mod;
    logic [cdds_pkg::DAY_W-1:0]    mlen_cur;
    logic [cdds_pkg::DAY_W-1:0]    mlen_in;
    logic [DN_W-1:0]               dn_fin;
    logic signed [TGT_W-1:0]       ylen_s;
    logic signed [TGT_W-1:0]       mlen_s;
    logic [5:0]                    wd_sum;

    assign leap     = (year_reg[1:0] == 2'b00) && ((c400_reg == '0) || (c100_reg != '0));
    assign ylen     = leap ? cdds_pkg::DAYS_LEAP : cdds_pkg::DAYS_COMMON;
    assign ylen_mod = leap ? 2'd2 : 2'd1;
    assign mlen_cur = cdds_pkg::month_len(mi_reg, leap);
    assign mlen_in  = cdds_pkg::month_len(m_in_reg, leap);
    assign dn_fin   = dn_reg + DN_W'(d_in_reg);
    assign ylen_s   = signed'(TGT_W'(ylen));
    assign mlen_s   = signed'(TGT_W'(mlen_cur));
    assign wd_sum   = {3'b000, wd_reg} + {1'b0, d_in_reg} - 6'd1;

    always_comb begin
        sts.in_ok = (y_in_reg >= FIRST_Y) && (y_in_reg <= LAST_Y)
                 && (m_in_reg >= cdds_pkg::MONTH_FIRST) && (m_in_reg <= cdds_pkg::NUM_MONTHS)
                 && (d_in_reg != '0);
        sts.at_year     = (year_reg == y_in_reg);
        sts.day_ok      = (d_in_reg <= mlen_in);
        sts.mon_done    = (mi_reg == m_in_reg);
        sts.tgt_pos     = !tgt_reg[TGT_W-1] && (tgt_reg != '0);
        sts.tgt_gt_ylen = (tgt_reg > ylen_s);
        sts.at_last     = (year_reg == LAST_Y);
        sts.tgt_gt_mon  = (mi_reg < cdds_pkg::NUM_MONTHS) && (tgt_reg > mlen_s);
        sts.out_free    = !ov_reg || m_tready;
    end

    always_comb begin
        y_in_next = y_in_reg;
        m_in_next = m_in_reg;
        d_in_next = d_in_reg;
        off_next  = off_reg;
        year_next = year_reg;
        c100_next = c100_reg;
        c400_next = c400_reg;
        dn_next   = dn_reg;
        wd_next   = wd_reg;
        mi_next   = mi_reg;
        tgt_next  = tgt_reg;
        ov_next   = ov_reg;
        o_dv_next = o_dv_reg;
        o_dn_next = o_dn_reg;
        o_wd_next = o_wd_reg;
        o_ok_next = o_ok_reg;
        o_y_next  = o_y_reg;
        o_m_next  = o_m_reg;
        o_d_next  = o_d_reg;

        if (cmd.year_step || cmd.tgt_year_step) begin
            year_next = year_reg + 12'd1;
            c100_next = (c100_reg == cdds_pkg::CENT_LAST) ? '0 : c100_reg + 7'd1;
            c400_next = (c400_reg == cdds_pkg::QCENT_LAST) ? '0 : c400_reg + 9'd1;
        end
        if (cmd.load || cmd.finish) begin
            year_next = FIRST_Y;
            c100_next = F100;
            c400_next = F400;
            mi_next   = cdds_pkg::MONTH_FIRST;
        end
        if (cmd.load) begin
            y_in_next = in_year;
            m_in_next = in_month;
            d_in_next = in_day;
            off_next  = in_offset_days;
            dn_next   = '0;
            wd_next   = WD0;
        end
        if (cmd.year_step) begin
            dn_next = dn_reg + DN_W'(ylen);
            wd_next = cdds_pkg::add_mod7(wd_reg, ylen_mod);
        end
        if (cmd.mon_step) begin
            dn_next = dn_reg + DN_W'(mlen_cur);
            // 28..31 days leave 0..3 mod 7
            wd_next = cdds_pkg::add_mod7(wd_reg, mlen_cur[1:0]);
            mi_next = mi_reg + 4'd1;
        end
        if (cmd.finish) begin
            dn_next  = dn_fin;
            wd_next  = cdds_pkg::fold_mod7(wd_sum);
            tgt_next = signed'(TGT_W'(dn_fin)) + TGT_W'(off_reg);
        end
        if (cmd.tgt_year_step) begin
            tgt_next = tgt_reg - ylen_s;
        end
        if (cmd.tgt_mon_step) begin
            tgt_next = tgt_reg - mlen_s;
            mi_next  = mi_reg + 4'd1;
        end

        if (ov_reg && m_tready) begin
            ov_next = 1'b0;
        end
        if (cmd.wr_ok || cmd.wr_fail) begin
            ov_next   = 1'b1;
            o_dv_next = 1'b1;
            o_dn_next = dn_reg[cdds_pkg::DN_OUT_W-1:0];
            o_wd_next = wd_reg + 3'd1;
            o_ok_next = cmd.wr_ok;
            o_y_next  = cmd.wr_ok ? year_reg : y_in_reg;
            o_m_next  = cmd.wr_ok ? mi_reg : m_in_reg;
            o_d_next  = cmd.wr_ok ? tgt_reg[cdds_pkg::DAY_W-1:0] : d_in_reg;
        end
        if (cmd.wr_inv) begin
            ov_next   = 1'b1;
            o_dv_next = 1'b0;
            o_dn_next = '0;
            o_wd_next = '0;
            o_ok_next = 1'b0;
            o_y_next  = '0;
            o_m_next  = '0;
            o_d_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        y_in_reg <= y_in_next;
        m_in_reg <= m_in_next;
        d_in_reg <= d_in_next;
        off_reg  <= off_next;
        year_reg <= year_next;
        c100_reg <= c100_next;
        c400_reg <= c400_next;
        dn_reg   <= dn_next;
        wd_reg   <= wd_next;
        mi_reg   <= mi_next;
        tgt_reg  <= tgt_next;
        o_dv_reg <= o_dv_next;
        o_dn_reg <= o_dn_next;
        o_wd_reg <= o_wd_next;
        o_ok_reg <= o_ok_next;
        o_y_reg  <= o_y_next;
        o_m_reg  <= o_m_next;
        o_d_reg  <= o_d_next;
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else begin
            ov_reg <= ov_next;
        end
    end

    assign m_tvalid       = ov_reg;
    assign out_date_valid = o_dv_reg;
    assign out_day_number = o_dn_reg;
    assign out_weekday    = o_wd_reg;
    assign out_shift_ok   = o_ok_reg;
    assign out_new_year   = o_y_reg;
    assign out_new_month  = o_m_reg;
    assign out_new_day    = o_d_reg;

`ifndef SYNTHESIS
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (ov_reg && !o_dv_reg) |-> (o_dn_reg == '0 && o_wd_reg == '0 && !o_ok_reg
                                   && o_y_reg == '0 && o_m_reg == '0 && o_d_reg == '0))
        else $error("invalid date word carries nonzero fields");

    a_century_align: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cmd.year_step || cmd.tgt_year_step || cmd.load || cmd.finish)
        |-> ((c400_reg != '0) || (c100_reg == '0)))
        else $error("century counters out of step");
`endif

endmodule

// ----- hdl/civil_date_day_number_shift_unit.sv -----
// Gregorian date unit: takes a date (year, month, day) and a signed day offset, checks the
// date against FIRST_YEAR..LAST_YEAR, the month range and the month length (leap years by
// the 4/100/400 rule), and returns the day number (1 January of FIRST_YEAR is day 1, low 16
// bits shown), the weekday (1 Monday .. 7 Sunday) and the date that lies offset days away.
// An invalid date gives a word of all zeros; a shift to day 0 or less, or past the end of
// LAST_YEAR, clears shift_ok and echoes the input date. One word is in work at a time. The
// year walker steps one year per cycle twice (once to build the day number, once to take
// the shifted number apart), and the month stepper runs after each year walk. A date out
// of range is written as invalid right after the range check, a day past the month end
// after the first year walk, and a failed shift ends early after its second year walk.
// A result write also waits while the output register is still full. A finished word
// waits in the output register while the next word is taken.
module civil_date_day_number_shift_unit #(
    parameter int FIRST_YEAR = 1970,
    parameter int LAST_YEAR  = 2099
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // year [11:0], month [15:12], day [20:16], offset_days [37:21] (signed), zero [39:38]
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // date_valid [0], day_number [16:1], weekday [19:17], shift_ok [20],
    // new_year [32:21], new_month [36:33], new_day [41:37], zero [47:42]
    output logic [47:0] m_tdata
);

    cdds_pkg::cmd_t cmd;
    cdds_pkg::sts_t sts;

    logic                              out_date_valid;
    logic [cdds_pkg::DN_OUT_W-1:0]     out_day_number;
    logic [cdds_pkg::WD_W-1:0]         out_weekday;
    logic                              out_shift_ok;
    logic [cdds_pkg::YEAR_W-1:0]       out_new_year;
    logic [cdds_pkg::MONTH_W-1:0]      out_new_month;
    logic [cdds_pkg::DAY_W-1:0]        out_new_day;

    // sequencer: range check, two year walks, two month walks, result write
    cdds_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // year walker, day accumulator, weekday counter and output register
    cdds_dp #(
        .FIRST_YEAR (FIRST_YEAR),
        .LAST_YEAR  (LAST_YEAR)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_year        (s_tdata[11:0]),
        .in_month       (s_tdata[15:12]),
        .in_day         (s_tdata[20:16]),
        .in_offset_days (signed'(s_tdata[37:21])),
        .cmd            (cmd),
        .sts            (sts),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .out_date_valid (out_date_valid),
        .out_day_number (out_day_number),
        .out_weekday    (out_weekday),
        .out_shift_ok   (out_shift_ok),
        .out_new_year   (out_new_year),
        .out_new_month  (out_new_month),
        .out_new_day    (out_new_day)
    );

    // pack the result word, lowest field last
    assign m_tdata = {6'b000000, out_new_day, out_new_month, out_new_year, out_shift_ok,
                      out_weekday, out_day_number, out_date_valid};

endmodule

// ----- verif/civil_date_day_number_shift_unit_tb.sv -----
module civil_date_day_number_shift_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int YEAR_W   = cdds_pkg::YEAR_W;
    localparam int MONTH_W  = cdds_pkg::MONTH_W;
    localparam int DAY_W    = cdds_pkg::DAY_W;
    localparam int OFF_W    = cdds_pkg::OFF_W;
    localparam int DN_OUT_W = cdds_pkg::DN_OUT_W;
    localparam int WD_W     = cdds_pkg::WD_W;

    localparam int FIRST_YEAR   = 1970;
    localparam int LAST_YEAR    = 2099;
    // limit far above the slowest word
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 1500;
    localparam int SETTLE_CYCLES = 400;

    // input word, lowest field last
    typedef struct packed {
        logic [1:0]               pad;
        logic signed [OFF_W-1:0]  offset;
        logic [DAY_W-1:0]         day;
        logic [MONTH_W-1:0]       month;
        logic [YEAR_W-1:0]        year;
    } date_word_t;

    // result word, lowest field last
    typedef struct packed {
        logic [DAY_W-1:0]    new_day;
        logic [MONTH_W-1:0]  new_month;
        logic [YEAR_W-1:0]   new_year;
        logic                shift_ok;
        logic [WD_W-1:0]     weekday;
        logic [DN_OUT_W-1:0] day_number;
        logic                date_valid;
    } date_result_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    // expected results in order of acceptance
    date_result_t expected_shifts[$];

    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    logic   output_hold = 1'b0;
    event   hold_request;
    int     cycle_count = 0;
    int     mismatch_count = 0;
    int     words_sent = 0;
    int     valid_dates = 0;
    int     failed_shifts = 0;
    int     results_checked = 0;
    longint last_day;

    civil_date_day_number_shift_unit #(
        .FIRST_YEAR (FIRST_YEAR),
        .LAST_YEAR  (LAST_YEAR)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // calendar arithmetic for the predictor
    // ---------------------------------------------------------------

    // 4/100/400 rule
    function automatic bit leap_year(input int y);
        return (y % 4 == 0) && ((y % 400 == 0) || (y % 100 != 0));
    endfunction

    function automatic int days_in(input int m, input int y);
        case (m)
            1, 3, 5, 7, 8, 10, 12:     return 31;
            4, 6, 9, 11:               return 30;
            int'(cdds_pkg::MONTH_FEB): return leap_year(y) ? 29 : 28;
            default:                   return 0;
        endcase
    endfunction

    function automatic int year_days(input int y);
        return leap_year(y) ? int'(cdds_pkg::DAYS_LEAP) : int'(cdds_pkg::DAYS_COMMON);
    endfunction

    // days from 1 january of year 1 up to 1 january of year y
    function automatic longint days_before_year(input int y);
        longint p;
        p = y - 1;
        return 365 * p + p / 4 - p / 100 + p / 400;
    endfunction

    // 1 january of FIRST_YEAR is day 1
    function automatic longint day_number_of(input int y, input int m, input int d);
        longint dn;
        dn = days_before_year(y) - days_before_year(FIRST_YEAR);
        for (int i = 1; i < m; i++) begin
            dn += days_in(i, y);
        end
        return dn + d;
    endfunction

    // full expected result word for one input word
    function automatic date_result_t predict_date_shift(input date_word_t w);
        date_result_t r;
        int           y, m, d, ny, nm;
        longint       dn, tgt;
        bit           ok;
        r = '0;
        y = int'(w.year);
        m = int'(w.month);
        d = int'(w.day);
        // bad date: everything stays zero
        if (y < FIRST_YEAR || y > LAST_YEAR || m < 1 || m > int'(cdds_pkg::NUM_MONTHS) ||
            d < 1 || d > days_in(m, y)) begin
            return r;
        end
        dn = day_number_of(y, m, d);
        r.date_valid = 1'b1;
        r.day_number = dn[DN_OUT_W-1:0];
        // year 1 starts on a monday
        r.weekday = WD_W'((days_before_year(FIRST_YEAR) + dn - 1) % cdds_pkg::WEEK_DAYS + 1);
        tgt = dn + longint'($signed(w.offset));
        ok  = (tgt > 0);
        ny  = FIRST_YEAR;
        nm  = 1;
        // walk whole years, running off the end kills the shift
        while (ok && tgt > year_days(ny)) begin
            tgt -= year_days(ny);
            ny++;
            if (ny > LAST_YEAR) begin
                ok = 1'b0;
            end
        end
        if (ok) begin
            while (nm < int'(cdds_pkg::NUM_MONTHS) && tgt > days_in(nm, ny)) begin
                tgt -= days_in(nm, ny);
                nm++;
            end
            r.shift_ok  = 1'b1;
            r.new_year  = YEAR_W'(ny);
            r.new_month = MONTH_W'(nm);
            r.new_day   = tgt[DAY_W-1:0];
        end else begin
            // failed shift echoes the input date
            r.new_year  = w.year;
            r.new_month = w.month;
            r.new_day   = w.day;
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    function automatic date_word_t date_word(input int y, input int m, input int d,
                                             input int off);
        date_word_t w;
        w        = '0;
        w.year   = YEAR_W'(y);
        w.month  = MONTH_W'(m);
        w.day    = DAY_W'(d);
        w.offset = OFF_W'(off);
        return w;
    endfunction

    // existing date, offset aimed at small moves, the full range or the range ends
    function automatic date_word_t random_real_date();
        int     y, m, d, len, off;
        longint dn;
        case ($urandom_range(0, 9))
            0:       y = FIRST_YEAR;
            1:       y = LAST_YEAR;
            2:       y = 2000;
            default: y = $urandom_range(FIRST_YEAR, LAST_YEAR);
        endcase
        m   = $urandom_range(1, 12);
        len = days_in(m, y);
        d   = ($urandom_range(0, 4) == 0) ? len : $urandom_range(1, len);
        dn  = day_number_of(y, m, d);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: off = int'($urandom_range(0, 1000)) - 500;
            4, 5:       off = int'($urandom_range(0, 131071)) - 65536;
            6, 7:       off = int'(-dn) + int'($urandom_range(0, 6)) - 3;
            default:    off = int'(last_day - dn) + int'($urandom_range(0, 6)) - 3;
        endcase
        return date_word(y, m, d, off);
    endfunction

    // raw bits, years just outside the range, bad months, one day too many
    function automatic date_word_t random_noise_date();
        logic [63:0] bits;
        int          y, m;
        y    = $urandom_range(FIRST_YEAR, LAST_YEAR);
        m    = $urandom_range(1, 12);
        bits = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0, 1: return date_word_t'({2'b00, bits[37:0]});
            2: return date_word($urandom_range(0, 1) ? FIRST_YEAR - 1 : LAST_YEAR + 1,
                                m, 1, int'(bits[16:0]));
            default: begin
                if ($urandom_range(0, 1)) begin
                    return date_word(y, m, days_in(m, y) + 1, int'(bits[16:0]));
                end
                return date_word(y, $urandom_range(0, 1) ? 0 : $urandom_range(13, 15), 1,
                                 int'(bits[16:0]));
            end
        endcase
    endfunction

    // offer one word, with a random gap in front, and log what it should give
    task automatic send_date(input date_word_t w);
        date_result_t want;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge aclk); while (s_tready !== 1'b1);
        want = predict_date_shift(w);
        expected_shifts.push_back(want);
        words_sent++;
        if (want.date_valid) valid_dates++;
        if (want.date_valid && !want.shift_ok) failed_shifts++;
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_shifts.size() != 0) @(posedge aclk);
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // first and last day, shifts onto and just past both ends
    task automatic test_range_edges();
        send_date(date_word(FIRST_YEAR, 1, 1, 0));
        send_date(date_word(LAST_YEAR, 12, 31, 0));
        send_date(date_word(FIRST_YEAR, 1, 1, 65535));
        send_date(date_word(LAST_YEAR, 12, 31, -65536));
        send_date(date_word(LAST_YEAR, 12, 31, 1));
        send_date(date_word(FIRST_YEAR, 1, 1, -1));
        send_date(date_word(LAST_YEAR, 12, 31, int'(1 - last_day)));
        send_date(date_word(FIRST_YEAR, 1, 1, int'(last_day - 1)));
    endtask

    // leap day checks and shifts across february and new year
    task automatic test_leap_days();
        send_date(date_word(2000, 2, 29, 0));
        send_date(date_word(1972, 2, 29, 365));
        send_date(date_word(1971, 2, 29, 0));
        send_date(date_word(2000, 2, 28, 1));
        send_date(date_word(1999, 12, 31, 1));
        send_date(date_word(2096, 2, 29, -1461));
    endtask

    // dates that do not exist or lie out of range, year, month and day field extremes
    task automatic test_invalid_dates();
        send_date(date_word(0, 0, 0, 0));
        send_date(date_word(4095, 15, 31, -1));
        send_date(date_word(FIRST_YEAR - 1, 12, 31, 5));
        send_date(date_word(LAST_YEAR + 1, 1, 1, 0));
        send_date(date_word(2024, 13, 1, 0));
        send_date(date_word(2024, 4, 31, 0));
        send_date(date_word(2024, 1, 0, 0));
    endtask

    // mostly real dates, a fifth noise
    task automatic test_random_mix(input int count);
        for (int i = 0; i < count; i++) begin
            send_date(($urandom_range(0, 4) == 0) ? random_noise_date() : random_real_date());
        end
    endtask

    // receiver holds off while words keep coming, so the input stalls
    task automatic test_output_backpressure(input int count);
        -> hold_request;
        for (int i = 0; i < count; i++) begin
            send_date(random_real_date());
        end
    endtask

    // ---------------------------------------------------------------
    // receiver side
    // ---------------------------------------------------------------

    // long hold-off, counted here
    always @(hold_request) begin
        output_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        output_hold <= 1'b0;
    end

    always @(posedge aclk) begin
        if (output_hold) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t ns: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    // check every accepted result word against the oldest expectation
    always @(posedge aclk) begin
        date_result_t want, got;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            got = m_tdata[41:0];
            if (expected_shifts.size() == 0) begin
                mismatch_count++;
                $display("%0t ns: result word %h with nothing expected", $time, m_tdata);
            end else begin
                want = expected_shifts.pop_front();
                results_checked++;
                compare_field("date_valid", 32'(want.date_valid), 32'(got.date_valid));
                compare_field("day_number", 32'(want.day_number), 32'(got.day_number));
                compare_field("weekday",    32'(want.weekday),    32'(got.weekday));
                compare_field("shift_ok",   32'(want.shift_ok),   32'(got.shift_ok));
                compare_field("new_year",   32'(want.new_year),   32'(got.new_year));
                compare_field("new_month",  32'(want.new_month),  32'(got.new_month));
                compare_field("new_day",    32'(want.new_day),    32'(got.new_day));
                compare_field("pad bits",   32'd0,                32'(m_tdata[47:42]));
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t ns: timeout with %0d results outstanding", $time,
                     expected_shifts.size());
            $display("civil_date_day_number_shift_unit verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        last_day = days_before_year(LAST_YEAR + 1) - days_before_year(FIRST_YEAR);
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sender mostly busy, receiver mostly stalling
        send_idle_pct = 13;
        recv_idle_pct = 75;
        test_range_edges();
        test_leap_days();
        test_invalid_dates();
        drain_results();
        test_random_mix(230);
        drain_results();

        // sender sparse, receiver mostly ready
        send_idle_pct = 75;
        recv_idle_pct = 13;
        test_random_mix(230);
        drain_results();

        // no idling anywhere, apart from the long hold-off
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_output_backpressure(24);
        drain_results();
        test_random_mix(220);
        drain_results();

        // let any stray word show up
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_shifts.size() != 0) begin
            mismatch_count++;
            $display("%0t ns: %0d expected results never arrived", $time,
                     expected_shifts.size());
        end

        $display("sent %0d date words (%0d existing dates, %0d shifts out of range)",
                 words_sent, valid_dates, failed_shifts);
        $display("checked %0d result words across three idling mixes and one long stall",
                 results_checked);
        if (mismatch_count == 0) begin
            $display("civil_date_day_number_shift_unit verification clean");
        end else begin
            $display("civil_date_day_number_shift_unit verification failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/cdds_pkg.sv
hdl/cdds_ctrl.sv
hdl/cdds_dp.sv
hdl/civil_date_day_number_shift_unit.sv
verif/civil_date_day_number_shift_unit_tb.sv
